>>> rtl/mdfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mdfp_pkg
// Shared types, constants and name tables for the mail date field parser.
// ----------------------------------------------------------------------------
package mdfp_pkg;

    localparam int POS_W       = 10;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;

    typedef enum logic [3:0] {
        PH_WDAY      = 4'd0,
        PH_DAY_LEAD  = 4'd1,
        PH_DAY_TOK   = 4'd2,
        PH_MON_LEAD  = 4'd3,
        PH_MON_TOK   = 4'd4,
        PH_YEAR_LEAD = 4'd5,
        PH_YEAR_TOK  = 4'd6,
        PH_HOUR      = 4'd7,
        PH_MIN       = 4'd8,
        PH_SEC       = 4'd9,
        PH_ZONE_LEAD = 4'd10,
        PH_ZONE_TOK  = 4'd11,
        PH_DONE      = 4'd12,
        PH_FAILED    = 4'd14
    } phase_t;

    typedef enum logic [1:0] {
        NUM_LEAD   = 2'd0,
        NUM_DIGITS = 2'd1,
        NUM_END    = 2'd2
    } num_mode_t;

    typedef struct packed {
        logic       is_nul;
        logic       is_space;
        logic       is_ws;
        logic       is_comma;
        logic       is_colon;
        logic       is_plus;
        logic       is_minus;
        logic       is_digit;
        logic [3:0] digit;
    } char_class_t;

    typedef struct packed {
        logic [7:0]  ch;
        char_class_t cls;
        logic        last;
    } queue_entry_t;

    typedef logic [23:0] name_t;

    localparam name_t DAY_NAMES [7] = '{
        24'h53756E, 24'h4D6F6E, 24'h547565, 24'h576564,
        24'h546875, 24'h467269, 24'h536174
    };

    localparam name_t MONTH_NAMES [12] = '{
        24'h4A616E, 24'h466562, 24'h4D6172, 24'h417072,
        24'h4D6179, 24'h4A756E, 24'h4A756C, 24'h417567,
        24'h536570, 24'h4F6374, 24'h4E6F76, 24'h446563
    };

    function automatic logic [2:0] weekday_lookup(input name_t chars);
        logic [2:0] code;
        code = 3'd0;
        for (int i = 6; i >= 0; i--) begin
            if (DAY_NAMES[i] == chars) begin
                code = 3'(i + 1);
            end
        end
        return code;
    endfunction

    function automatic logic [3:0] month_lookup(input name_t chars);
        logic [3:0] code;
        code = 4'd0;
        for (int i = 11; i >= 0; i--) begin
            if (MONTH_NAMES[i] == chars) begin
                code = 4'(i + 1);
            end
        end
        return code;
    endfunction

endpackage
`default_nettype wire

>>> rtl/mdfp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mdfp_front
// Input side: accepts byte beats and tags each with its character class.
// ----------------------------------------------------------------------------
module mdfp_front
(
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // [7:0] text_byte
    input  wire logic                  s_tlast,   // last_byte
    input  wire logic                  q_full,
    output logic                       push,
    output mdfp_pkg::queue_entry_t     push_entry
);

    logic [7:0] ch;

    // tab folds into space
    assign ch       = (s_tdata == mdfp_pkg::CH_TAB) ? mdfp_pkg::CH_SPACE : s_tdata;
    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    always_comb
    begin
        push_entry              = '0;
        push_entry.ch           = ch;
        push_entry.last         = s_tlast;
        push_entry.cls.is_nul   = (s_tdata == mdfp_pkg::CH_NUL);
        push_entry.cls.is_space = (ch == mdfp_pkg::CH_SPACE);
        push_entry.cls.is_ws    = (ch == mdfp_pkg::CH_SPACE) ||
                                  ((ch >= mdfp_pkg::CH_TAB) && (ch <= mdfp_pkg::CH_CR));
        push_entry.cls.is_comma = (ch == mdfp_pkg::CH_COMMA);
        push_entry.cls.is_colon = (ch == mdfp_pkg::CH_COLON);
        push_entry.cls.is_plus  = (ch == mdfp_pkg::CH_PLUS);
        push_entry.cls.is_minus = (ch == mdfp_pkg::CH_MINUS);
        push_entry.cls.is_digit = (ch >= mdfp_pkg::CH_ZERO) && (ch <= mdfp_pkg::CH_NINE);
        push_entry.cls.digit    = 4'(ch - mdfp_pkg::CH_ZERO);
    end

endmodule
`default_nettype wire

>>> rtl/mdfp_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mdfp_queue
// Small FIFO of classified bytes between the front and back ends.
// ----------------------------------------------------------------------------
module mdfp_queue
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire mdfp_pkg::queue_entry_t push_entry,
    output logic                        full,
    input  wire logic                   pop,
    output logic                        q_valid,
    output mdfp_pkg::queue_entry_t      q_entry
);

    mdfp_pkg::queue_entry_t mem [mdfp_pkg::QUEUE_DEPTH];

    logic [mdfp_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [mdfp_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [mdfp_pkg::QCNT_W-1:0] count_reg,  count_next;

    assign full    = (count_reg == mdfp_pkg::QCNT_W'(mdfp_pkg::QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_entry = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + mdfp_pkg::QCNT_W'(push) - mdfp_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/mdfp_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mdfp_back
// Parser state machine, field accumulators and result register.
// ----------------------------------------------------------------------------
module mdfp_back
#(
    parameter int MAX_STRING_LENGTH = 1024
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   q_valid,
    input  wire mdfp_pkg::queue_entry_t q_entry,
    output logic                        pop,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [79:0]                 m_tdata,
    output logic [1:0]                  m_tuser
);

    localparam int PosLimitInt = ((MAX_STRING_LENGTH - 1) < 1023) ? (MAX_STRING_LENGTH - 1) : 1023;
    localparam logic [mdfp_pkg::POS_W-1:0] POS_LIMIT = mdfp_pkg::POS_W'(PosLimitInt);

    mdfp_pkg::phase_t    phase_reg, phase_next;
    mdfp_pkg::num_mode_t mode_reg,  mode_next;
    mdfp_pkg::name_t     chars_reg, chars_next;
    logic [2:0]          count_reg, count_next;
    logic [15:0]         acc_reg,   acc_next;
    logic                neg_reg,   neg_next;
    logic [mdfp_pkg::POS_W-1:0] pos_reg,    pos_next;
    logic [2:0]          weekday_reg, weekday_next;
    logic [7:0]          day_reg,     day_next;
    logic [3:0]          month_reg,   month_next;
    logic [15:0]         year_reg,    year_next;
    logic [7:0]          hour_reg,    hour_next;
    logic [7:0]          minute_reg,  minute_next;
    logic [7:0]          second_reg,  second_next;
    logic [mdfp_pkg::POS_W-1:0] zstart_reg, zstart_next;
    logic [mdfp_pkg::POS_W-1:0] zlen_reg,   zlen_next;

    logic                 out_valid_reg;
    logic [79:0]          out_data_reg;
    logic [1:0]           out_user_reg;

    mdfp_pkg::char_class_t cls;
    logic        active;
    logic        step;
    logic        ok;
    logic        zone;

    mdfp_pkg::name_t nf_chars;
    logic [2:0]      nf_count;
    logic [2:0]      wd_code;
    logic [3:0]      mon_code;

    logic [19:0]         mul10;
    logic [15:0]         nf_acc;
    logic                nf_neg;
    mdfp_pkg::num_mode_t nf_mode;
    logic [7:0]          take8;
    logic [15:0]         take16;

    assign cls    = q_entry.cls;
    assign pop    = q_valid && (!q_entry.last || !out_valid_reg || m_tready);
    assign active = (phase_reg != mdfp_pkg::PH_DONE) && (phase_reg != mdfp_pkg::PH_FAILED);
    assign step   = active && !cls.is_nul;

    // name shift register
    assign nf_chars = {chars_reg[15:0], q_entry.ch};
    assign nf_count = (count_reg < 3'd3) ? count_reg + 3'd1 : 3'd4;
    assign wd_code  = (count_reg == 3'd3) ? mdfp_pkg::weekday_lookup(chars_reg) : 3'd0;
    assign mon_code = (count_reg == 3'd3) ? mdfp_pkg::month_lookup(chars_reg) : 4'd0;

    // atoi step
    assign mul10 = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} + {16'd0, cls.digit};

    always_comb
    begin
        nf_acc  = acc_reg;
        nf_neg  = neg_reg;
        nf_mode = mode_reg;
        unique case (mode_reg)
            mdfp_pkg::NUM_LEAD:
            begin
                if (cls.is_ws)
                begin
                    nf_mode = mdfp_pkg::NUM_LEAD;
                end
                else if (cls.is_plus)
                begin
                    nf_mode = mdfp_pkg::NUM_DIGITS;
                end
                else if (cls.is_minus)
                begin
                    nf_neg  = 1'b1;
                    nf_mode = mdfp_pkg::NUM_DIGITS;
                end
                else if (cls.is_digit)
                begin
                    nf_acc  = {12'd0, cls.digit};
                    nf_mode = mdfp_pkg::NUM_DIGITS;
                end
                else
                begin
                    nf_mode = mdfp_pkg::NUM_END;
                end
            end
            mdfp_pkg::NUM_DIGITS:
            begin
                if (cls.is_digit)
                begin
                    nf_acc = (mul10[19:16] != 4'd0) ? 16'hFFFF : mul10[15:0];
                end
                else
                begin
                    nf_mode = mdfp_pkg::NUM_END;
                end
            end
            default:
            begin
                nf_mode = mode_reg;
            end
        endcase
    end

    // saturating signed takes
    always_comb
    begin
        if (neg_reg)
        begin
            take8  = (acc_reg > 16'd128)   ? 8'h80   : 8'(~acc_reg + 16'd1);
            take16 = (acc_reg > 16'd32768) ? 16'h8000 : (~acc_reg + 16'd1);
        end
        else
        begin
            take8  = (acc_reg > 16'd127)   ? 8'h7F   : acc_reg[7:0];
            take16 = (acc_reg > 16'd32767) ? 16'h7FFF : acc_reg;
        end
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (active && cls.is_nul)
        begin
            phase_next = (phase_reg >= mdfp_pkg::PH_ZONE_LEAD) ? mdfp_pkg::PH_DONE
                                                              : mdfp_pkg::PH_FAILED;
        end
        else if (step)
        begin
            unique case (phase_reg)
                mdfp_pkg::PH_WDAY:
                    if (cls.is_comma) phase_next = mdfp_pkg::PH_DAY_LEAD;
                mdfp_pkg::PH_DAY_LEAD:
                    if (!cls.is_space) phase_next = mdfp_pkg::PH_DAY_TOK;
                mdfp_pkg::PH_DAY_TOK:
                    if (cls.is_space) phase_next = mdfp_pkg::PH_MON_LEAD;
                mdfp_pkg::PH_MON_LEAD:
                    if (!cls.is_space) phase_next = mdfp_pkg::PH_MON_TOK;
                mdfp_pkg::PH_MON_TOK:
                    if (cls.is_space) phase_next = mdfp_pkg::PH_YEAR_LEAD;
                mdfp_pkg::PH_YEAR_LEAD:
                    if (!cls.is_space) phase_next = mdfp_pkg::PH_YEAR_TOK;
                mdfp_pkg::PH_YEAR_TOK:
                    if (cls.is_space) phase_next = mdfp_pkg::PH_HOUR;
                mdfp_pkg::PH_HOUR:
                    if (cls.is_colon) phase_next = mdfp_pkg::PH_MIN;
                mdfp_pkg::PH_MIN:
                    if (cls.is_colon) phase_next = mdfp_pkg::PH_SEC;
                mdfp_pkg::PH_SEC:
                    if (cls.is_space) phase_next = mdfp_pkg::PH_ZONE_LEAD;
                mdfp_pkg::PH_ZONE_LEAD:
                    if (!cls.is_space) phase_next = mdfp_pkg::PH_ZONE_TOK;
                mdfp_pkg::PH_ZONE_TOK:
                    if (cls.is_space) phase_next = mdfp_pkg::PH_DONE;
                default:
                    phase_next = mdfp_pkg::PH_FAILED;
            endcase
        end
    end

    // field updates
    always_comb
    begin
        chars_next   = chars_reg;
        count_next   = count_reg;
        acc_next     = acc_reg;
        neg_next     = neg_reg;
        mode_next    = mode_reg;
        weekday_next = weekday_reg;
        day_next     = day_reg;
        month_next   = month_reg;
        year_next    = year_reg;
        hour_next    = hour_reg;
        minute_next  = minute_reg;
        second_next  = second_reg;
        zstart_next  = zstart_reg;
        zlen_next    = zlen_reg;
        pos_next     = (pos_reg < POS_LIMIT) ? pos_reg + 1'b1 : pos_reg;

        if (step)
        begin
            unique case (phase_reg)
                mdfp_pkg::PH_WDAY:
                begin
                    if (cls.is_comma)
                    begin
                        weekday_next = wd_code;
                        chars_next   = '0;
                        count_next   = '0;
                    end
                    else if (!(cls.is_space && count_reg == 3'd0))
                    begin
                        chars_next = (count_reg < 3'd3) ? nf_chars : chars_reg;
                        count_next = nf_count;
                    end
                end
                mdfp_pkg::PH_DAY_LEAD, mdfp_pkg::PH_YEAR_LEAD:
                begin
                    if (!cls.is_space)
                    begin
                        acc_next  = nf_acc;
                        neg_next  = nf_neg;
                        mode_next = nf_mode;
                    end
                end
                mdfp_pkg::PH_MON_LEAD, mdfp_pkg::PH_MON_TOK:
                begin
                    if (phase_reg == mdfp_pkg::PH_MON_TOK && cls.is_space)
                    begin
                        month_next = mon_code;
                        chars_next = '0;
                        count_next = '0;
                    end
                    else if (!cls.is_space)
                    begin
                        chars_next = (count_reg < 3'd3) ? nf_chars : chars_reg;
                        count_next = nf_count;
                    end
                end
                mdfp_pkg::PH_DAY_TOK, mdfp_pkg::PH_YEAR_TOK, mdfp_pkg::PH_HOUR,
                mdfp_pkg::PH_MIN, mdfp_pkg::PH_SEC:
                begin
                    if (phase_next != phase_reg)
                    begin
                        acc_next  = '0;
                        neg_next  = 1'b0;
                        mode_next = mdfp_pkg::NUM_LEAD;
                        unique case (phase_reg)
                            mdfp_pkg::PH_DAY_TOK:  day_next    = take8;
                            mdfp_pkg::PH_YEAR_TOK: year_next   = take16;
                            mdfp_pkg::PH_HOUR:     hour_next   = take8;
                            mdfp_pkg::PH_MIN:      minute_next = take8;
                            default:               second_next = take8;
                        endcase
                    end
                    else
                    begin
                        acc_next  = nf_acc;
                        neg_next  = nf_neg;
                        mode_next = nf_mode;
                    end
                end
                mdfp_pkg::PH_ZONE_LEAD:
                begin
                    if (!cls.is_space)
                    begin
                        zstart_next = pos_reg;
                        zlen_next   = mdfp_pkg::POS_W'(1);
                    end
                end
                mdfp_pkg::PH_ZONE_TOK:
                begin
                    if (!cls.is_space && zlen_reg < POS_LIMIT)
                    begin
                        zlen_next = zlen_reg + 1'b1;
                    end
                end
                default:
                begin
                    zlen_next = zlen_reg;
                end
            endcase
        end
    end

    assign ok   = (phase_next >= mdfp_pkg::PH_ZONE_LEAD) && (phase_next <= mdfp_pkg::PH_DONE);
    assign zone = ok && (zlen_next != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= mdfp_pkg::PH_WDAY;
            mode_reg    <= mdfp_pkg::NUM_LEAD;
            chars_reg   <= '0;
            count_reg   <= '0;
            acc_reg     <= '0;
            neg_reg     <= 1'b0;
            pos_reg     <= '0;
            weekday_reg <= '0;
            day_reg     <= '0;
            month_reg   <= '0;
            year_reg    <= '0;
            hour_reg    <= '0;
            minute_reg  <= '0;
            second_reg  <= '0;
            zstart_reg  <= '0;
            zlen_reg    <= '0;
        end
        else if (pop)
        begin
            if (q_entry.last)
            begin
                phase_reg   <= mdfp_pkg::PH_WDAY;
                mode_reg    <= mdfp_pkg::NUM_LEAD;
                chars_reg   <= '0;
                count_reg   <= '0;
                acc_reg     <= '0;
                neg_reg     <= 1'b0;
                pos_reg     <= '0;
                weekday_reg <= '0;
                day_reg     <= '0;
                month_reg   <= '0;
                year_reg    <= '0;
                hour_reg    <= '0;
                minute_reg  <= '0;
                second_reg  <= '0;
                zstart_reg  <= '0;
                zlen_reg    <= '0;
            end
            else
            begin
                phase_reg   <= phase_next;
                mode_reg    <= mode_next;
                chars_reg   <= chars_next;
                count_reg   <= count_next;
                acc_reg     <= acc_next;
                neg_reg     <= neg_next;
                pos_reg     <= pos_next;
                weekday_reg <= weekday_next;
                day_reg     <= day_next;
                month_reg   <= month_next;
                year_reg    <= year_next;
                hour_reg    <= hour_next;
                minute_reg  <= minute_next;
                second_reg  <= second_next;
                zstart_reg  <= zstart_next;
                zlen_reg    <= zlen_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop && q_entry.last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && q_entry.last)
        begin
            out_user_reg <= {zone, ok};
            out_data_reg <= ok ? {5'd0,
                                  zone ? zlen_next   : 10'd0,
                                  zone ? zstart_next : 10'd0,
                                  second_next, minute_next, hour_next, year_next,
                                  month_next, day_next, weekday_next}
                               : 80'd0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule
`default_nettype wire

>>> rtl/mail_date_field_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mail_date_field_parser
// Parses a mail date header streamed one byte per beat into its fields.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle, set by the parser step in the back end;
//   a stalled result only holds the back end on a last byte.
// Result path: the last input beat is registered in the byte queue, then
//   the result beat is registered in the result register.
// Reset: asynchronous, clears the queue, the parser state and the result
//   valid flag; the parser also returns to its reset state after each string.
module mail_date_field_parser
#(
    parameter int MAX_STRING_LENGTH = 1024
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] text_byte
    input  wire logic        s_tlast,   // last_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [2:0] weekday_code, [10:3] day_value, [14:11] month_code,
    // [30:15] year_value, [38:31] hour_value, [46:39] minute_value,
    // [54:47] second_value, [64:55] zone_start, [74:65] zone_length, [79:75] zero
    output logic [79:0]      m_tdata,
    output logic [1:0]       m_tuser    // [0] parse_ok, [1] zone_present
);

    logic                   push;
    logic                   pop;
    logic                   q_full;
    logic                   q_valid;
    mdfp_pkg::queue_entry_t push_entry;
    mdfp_pkg::queue_entry_t q_entry;

    mdfp_front u_front
    (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    mdfp_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_entry    (q_entry)
    );

    mdfp_back
    #(
        .MAX_STRING_LENGTH (MAX_STRING_LENGTH)
    )
    u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
`default_nettype wire

>>> rtl/mdfp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mdfp_checker
// Port-level checks on the result stream of the date parser.
// ----------------------------------------------------------------------------
module mdfp_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [79:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result beat changed while stalled");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == 80'd0 && !m_tuser[1]))
        else $error("failed parse carries nonzero fields");

    a_zone_len: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> (m_tdata[74:65] != 10'd0))
        else $error("zone present with zero length");

    a_no_zone: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[1]) |-> (m_tdata[74:55] == 20'd0))
        else $error("zone fields set without zone");

    a_codes: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[14:11] <= 4'd12 && m_tdata[79:75] == 5'd0))
        else $error("month code out of range or pad bits set");

endmodule

bind mail_date_field_parser mdfp_checker u_mdfp_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
